/* hw/rtl/orbit_camera_spherical_to_cartesian_assert.svh */
// assertion macros for the orbit camera block
`ifndef ORBIT_CAMERA_SPHERICAL_TO_CARTESIAN_ASSERT_SVH
`define ORBIT_CAMERA_SPHERICAL_TO_CARTESIAN_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OCAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OCAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ocam_pkg.sv */
// shared types, constants and tables of the orbit camera block
package ocam_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int KIND_W     = 2;
  localparam int DEG_W      = 17;
  localparam int DRAD_W     = 17;
  localparam int RAD_W      = 16;
  localparam int ANG_W      = 16;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int XY_W       = 33;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_ROTATE = 2'd0,
    KIND_ZOOM   = 2'd1,
    KIND_LOAD   = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEV_MIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEV_MAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_MIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_MAX  = 4'd3;

  localparam logic signed [ANG_W-1:0] ELEV_MIN_RST = -16'sd8192;
  localparam logic signed [ANG_W-1:0] ELEV_MAX_RST = 16'sd13653;
  localparam logic [RAD_W-1:0]        RAD_MIN_RST  = 16'd960;
  localparam logic [RAD_W-1:0]        RAD_MAX_RST  = 16'd4960;

  // degrees (9.8) to angle units: (mag*32 + 22) / 45 by reciprocal
  localparam logic [21:0] DEG_ROUND    = 22'd22;
  localparam logic [22:0] DEG_RECIP    = 23'd5965233;
  localparam int          DEG_RECIP_SH = 28;

  localparam logic signed [XY_W-1:0]  CORDIC_X0  = 33'sd652032874;
  localparam logic signed [XY_W-1:0]  CORDIC_LIM = 33'sd1073741824;
  localparam logic signed [MUL_W-1:0] TRIG_LIM   = 32'sd1073741824;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEG_AZ,
    S_DEG_EL,
    S_DEG_FIN,
    S_COR_PREP,
    S_COR_ITER,
    S_COR_END,
    S_MUL_T,
    S_MUL_Y,
    S_MUL_X,
    S_MUL_Z,
    S_OUT
  } state_t;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/ocam_in_if.sv */
// request channel of the orbit camera block
interface ocam_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [ocam_pkg::KIND_W-1:0]             kind;
  logic signed [ocam_pkg::DEG_W-1:0]       delta_azimuth_deg;
  logic signed [ocam_pkg::DEG_W-1:0]       delta_elevation_deg;
  logic signed [ocam_pkg::DRAD_W-1:0]      delta_radius;
  logic [ocam_pkg::RAD_W-1:0]              load_radius;
  logic [ocam_pkg::ANG_W-1:0]              load_azimuth;
  logic signed [ocam_pkg::ANG_W-1:0]       load_elevation;

  modport source (
    output valid, kind, delta_azimuth_deg, delta_elevation_deg, delta_radius,
           load_radius, load_azimuth, load_elevation,
    input  ready
  );
  modport sink (
    input  valid, kind, delta_azimuth_deg, delta_elevation_deg, delta_radius,
           load_radius, load_azimuth, load_elevation,
    output ready
  );
endinterface

/* hw/rtl/ocam_out_if.sv */
// result channel of the orbit camera block
interface ocam_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ocam_pkg::POS_W-1:0]  pos_x;
  logic signed [ocam_pkg::POS_W-1:0]  pos_y;
  logic signed [ocam_pkg::POS_W-1:0]  pos_z;
  logic [ocam_pkg::RAD_W-1:0]         cur_radius;
  logic [ocam_pkg::ANG_W-1:0]         cur_azimuth;
  logic signed [ocam_pkg::ANG_W-1:0]  cur_elevation;

  modport source (
    output valid, pos_x, pos_y, pos_z, cur_radius, cur_azimuth, cur_elevation,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, cur_radius, cur_azimuth, cur_elevation,
    output ready
  );
endinterface

/* hw/rtl/ocam_cfg_if.sv */
// register write channel of the orbit camera block
interface ocam_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ocam_pkg::CFG_IDX_W-1:0]      idx;
  logic [ocam_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

/* hw/rtl/orbit_camera_spherical_to_cartesian.sv */
// orbit camera: state update, shared cordic and shared multiplier
//
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | kind, deltas, load values
//  out_ch   | out | valid/ready  | pos_x/y/z, cur_radius/azimuth/elevation
//  cfg_ch   | in  | valid/ready  | idx, data (always ready)
//
// one request at a time: the next request is taken only after the result has moved
// into the output register; a rotate first converts its degree deltas, and every result
// comes from two passes of one cordic iteration unit and one 32x32 multiplier.
// rst_n is synchronous: clears state to zero and clamps to their defaults.
// a finished result waits in the output register; the next request is taken
// meanwhile and only stalls at its own output step.
`include "orbit_camera_spherical_to_cartesian_assert.svh"

module orbit_camera_spherical_to_cartesian #(
  parameter int ANGLE_BITS   = ocam_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = ocam_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ocam_in_if.sink           in_ch,
  ocam_out_if.source        out_ch,
  ocam_cfg_if.sink          cfg_ch
);

  localparam int Z_W    = ANGLE_BITS + 1;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  ocam_pkg::state_t state_r, state_nxt;

  logic signed [15:0] elev_min_r, elev_max_r;
  logic [15:0]        rad_min_r, rad_max_r;
  logic [15:0]        radius_r, azimuth_r;
  logic signed [15:0] elevation_r;

  logic signed [ocam_pkg::DEG_W-1:0] daz_r, del_r;
  logic                              pass_r;
  logic [STEP_W-1:0]                 step_r;
  logic                              flip_r;
  logic signed [ocam_pkg::XY_W-1:0]  cx_r, cy_r;
  logic signed [Z_W-1:0]             cz_r;
  logic signed [ocam_pkg::MUL_W-1:0] ce_r, se_r, ca_r, sa_r, t_r;
  logic signed [ocam_pkg::PROD_W-1:0] prod_r;
  logic signed [ocam_pkg::POS_W-1:0] px_r, py_r;

  logic                              out_valid_r;
  logic signed [ocam_pkg::POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [15:0]                       cur_radius_r, cur_azimuth_r;
  logic signed [15:0]                cur_elevation_r;

  logic                              in_acc;
  logic                              out_free;
  logic                              mul_en;
  logic signed [ocam_pkg::MUL_W-1:0] mul_a, mul_b;

  // rounds a product half up by sh bits and saturates to +-65535
  function automatic logic signed [ocam_pkg::POS_W-1:0] rnd_sat(
    input logic signed [ocam_pkg::PROD_W-1:0] p,
    input int unsigned sh
  );
    logic signed [ocam_pkg::PROD_W-1:0] v;
    v = (p + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v > 64'sd65535) begin
      return 17'sd65535;
    end else if (v < -64'sd65535) begin
      return -17'sd65535;
    end else begin
      return v[ocam_pkg::POS_W-1:0];
    end
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // degree delta to angle units
  logic signed [ocam_pkg::DEG_W-1:0] deg_sel;
  logic [16:0]                       deg_mag;
  logic [21:0]                       deg_num;
  logic [15:0]                       deg_q;
  logic                              deg_neg;
  logic signed [17:0]                deg_bau;

  assign deg_sel = (state_r == ocam_pkg::S_DEG_AZ) ? daz_r : del_r;
  assign deg_mag = deg_sel[16] ? (~deg_sel + 17'd1) : deg_sel;
  assign deg_num = {deg_mag, 5'b0} + ocam_pkg::DEG_ROUND;
  assign deg_q   = prod_r[ocam_pkg::DEG_RECIP_SH +: 16];
  assign deg_neg = (state_r == ocam_pkg::S_DEG_EL) ? daz_r[16] : del_r[16];
  assign deg_bau = deg_neg ? -$signed({2'b00, deg_q}) : $signed({2'b00, deg_q});

  // elevation step with clamp
  logic signed [17:0] el_sum, emin18, emax18;
  logic signed [15:0] el_new;
  assign el_sum = $signed({{2{elevation_r[15]}}, elevation_r}) + deg_bau;
  assign emin18 = {{2{elev_min_r[15]}}, elev_min_r};
  assign emax18 = {{2{elev_max_r[15]}}, elev_max_r};
  always_comb begin
    if (el_sum < emin18) begin
      el_new = elev_min_r;
    end else if (el_sum > emax18) begin
      el_new = elev_max_r;
    end else begin
      el_new = el_sum[15:0];
    end
  end

  // zoom with clamp
  logic signed [17:0] rad_sum, rmin18, rmax18;
  logic [15:0]        rad_new;
  assign rad_sum = $signed({2'b00, radius_r})
                 + $signed({in_ch.delta_radius[16], in_ch.delta_radius});
  assign rmin18  = $signed({2'b00, rad_min_r});
  assign rmax18  = $signed({2'b00, rad_max_r});
  always_comb begin
    if (rad_sum < rmin18) begin
      rad_new = rad_min_r;
    end else if (rad_sum > rmax18) begin
      rad_new = rad_max_r;
    end else begin
      rad_new = rad_sum[15:0];
    end
  end

  // elevation as seen by the trig, clamped for the elevation pass of every request
  logic signed [15:0] el_trig;
  always_comb begin
    if (elevation_r < elev_min_r) begin
      el_trig = elev_min_r;
    end else if (elevation_r > elev_max_r) begin
      el_trig = elev_max_r;
    end else begin
      el_trig = elevation_r;
    end
  end

  // cordic start angle, folded into the right half plane
  logic [15:0]           ang_src;
  logic [39:0]           ang_wide;
  logic [ANGLE_BITS-1:0] ang_a, ang_f;
  logic [1:0]            ang_q;
  logic                  ang_flip;
  logic signed [Z_W-1:0] ang_z0;
  assign ang_src  = pass_r ? azimuth_r : el_trig;
  assign ang_wide = {ang_src, 24'b0};
  assign ang_a    = ang_wide[39 -: ANGLE_BITS];
  assign ang_q    = ang_a[ANGLE_BITS-1 -: 2];
  assign ang_flip = (ang_q == 2'b01) || (ang_q == 2'b10);
  assign ang_f    = ang_flip ? {~ang_a[ANGLE_BITS-1], ang_a[ANGLE_BITS-2:0]} : ang_a;
  assign ang_z0   = $signed({ang_f[ANGLE_BITS-1], ang_f});

  // one cordic micro-rotation
  logic [31:0]                      atan_raw;
  logic [32:0]                      atan_rnd;
  logic signed [Z_W-1:0]            atan_z;
  logic signed [ocam_pkg::XY_W-1:0] x_sh, y_sh;
  assign atan_raw = ocam_pkg::cordic_atan(5'(step_r));
  assign atan_rnd = ({1'b0, atan_raw} + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
  assign atan_z   = $signed(atan_rnd[Z_W-1:0]);
  assign x_sh     = cx_r >>> step_r;
  assign y_sh     = cy_r >>> step_r;

  // clamp to unit and undo the half-turn fold
  logic signed [ocam_pkg::XY_W-1:0] x_cl, y_cl, x_fin, y_fin;
  always_comb begin
    if (cx_r > ocam_pkg::CORDIC_LIM) begin
      x_cl = ocam_pkg::CORDIC_LIM;
    end else if (cx_r < -ocam_pkg::CORDIC_LIM) begin
      x_cl = -ocam_pkg::CORDIC_LIM;
    end else begin
      x_cl = cx_r;
    end
    if (cy_r > ocam_pkg::CORDIC_LIM) begin
      y_cl = ocam_pkg::CORDIC_LIM;
    end else if (cy_r < -ocam_pkg::CORDIC_LIM) begin
      y_cl = -ocam_pkg::CORDIC_LIM;
    end else begin
      y_cl = cy_r;
    end
    x_fin = flip_r ? -x_cl : x_cl;
    y_fin = flip_r ? -y_cl : y_cl;
  end

  logic signed [ocam_pkg::PROD_W-1:0] t_sum;
  assign t_sum = prod_r + 64'sd32768;

  // sequencer: next state and multiplier operands
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_r)
      ocam_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == ocam_pkg::KIND_ROTATE) begin
            state_nxt = ocam_pkg::S_DEG_AZ;
          end else begin
            state_nxt = ocam_pkg::S_COR_PREP;
          end
        end
      end
      ocam_pkg::S_DEG_AZ, ocam_pkg::S_DEG_EL: begin
        mul_en    = 1'b1;
        mul_a     = $signed({10'b0, deg_num});
        mul_b     = $signed({9'b0, ocam_pkg::DEG_RECIP});
        state_nxt = (state_r == ocam_pkg::S_DEG_AZ) ? ocam_pkg::S_DEG_EL
                                                     : ocam_pkg::S_DEG_FIN;
      end
      ocam_pkg::S_DEG_FIN: begin
        state_nxt = ocam_pkg::S_COR_PREP;
      end
      ocam_pkg::S_COR_PREP: begin
        state_nxt = ocam_pkg::S_COR_ITER;
      end
      ocam_pkg::S_COR_ITER: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ocam_pkg::S_COR_END;
        end
      end
      ocam_pkg::S_COR_END: begin
        state_nxt = pass_r ? ocam_pkg::S_MUL_T : ocam_pkg::S_COR_PREP;
      end
      ocam_pkg::S_MUL_T: begin
        mul_en    = 1'b1;
        mul_a     = $signed({16'b0, radius_r});
        mul_b     = ce_r;
        state_nxt = ocam_pkg::S_MUL_Y;
      end
      ocam_pkg::S_MUL_Y: begin
        mul_en    = 1'b1;
        mul_a     = $signed({16'b0, radius_r});
        mul_b     = se_r;
        state_nxt = ocam_pkg::S_MUL_X;
      end
      ocam_pkg::S_MUL_X: begin
        mul_en    = 1'b1;
        mul_a     = t_r;
        mul_b     = sa_r;
        state_nxt = ocam_pkg::S_MUL_Z;
      end
      ocam_pkg::S_MUL_Z: begin
        mul_en    = 1'b1;
        mul_a     = t_r;
        mul_b     = ca_r;
        state_nxt = ocam_pkg::S_OUT;
      end
      ocam_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = ocam_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ocam_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ocam_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and camera state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elev_min_r  <= ocam_pkg::ELEV_MIN_RST;
      elev_max_r  <= ocam_pkg::ELEV_MAX_RST;
      rad_min_r   <= ocam_pkg::RAD_MIN_RST;
      rad_max_r   <= ocam_pkg::RAD_MAX_RST;
      radius_r    <= '0;
      azimuth_r   <= '0;
      elevation_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.idx)
          ocam_pkg::CFG_ELEV_MIN: elev_min_r <= $signed(cfg_ch.data);
          ocam_pkg::CFG_ELEV_MAX: elev_max_r <= $signed(cfg_ch.data);
          ocam_pkg::CFG_RAD_MIN:  rad_min_r  <= cfg_ch.data;
          ocam_pkg::CFG_RAD_MAX:  rad_max_r  <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_ch.kind)
          ocam_pkg::KIND_ZOOM: begin
            radius_r <= rad_new;
          end
          ocam_pkg::KIND_LOAD: begin
            radius_r    <= in_ch.load_radius;
            azimuth_r   <= in_ch.load_azimuth;
            elevation_r <= in_ch.load_elevation;
          end
          default: ;
        endcase
      end
      if (state_r == ocam_pkg::S_DEG_EL) begin
        azimuth_r <= azimuth_r + deg_bau[15:0];
      end
      if (state_r == ocam_pkg::S_DEG_FIN) begin
        elevation_r <= el_new;
      end
    end
  end

  assign cfg_ch.ready = 1'b1;

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      daz_r <= in_ch.delta_azimuth_deg;
      del_r <= in_ch.delta_elevation_deg;
    end
    if (mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    case (state_r)
      ocam_pkg::S_COR_PREP: begin
        cx_r   <= ocam_pkg::CORDIC_X0;
        cy_r   <= '0;
        cz_r   <= ang_z0;
        flip_r <= ang_flip;
        step_r <= '0;
      end
      ocam_pkg::S_COR_ITER: begin
        if (!cz_r[Z_W-1]) begin
          cx_r <= cx_r - y_sh;
          cy_r <= cy_r + x_sh;
          cz_r <= cz_r - atan_z;
        end else begin
          cx_r <= cx_r + y_sh;
          cy_r <= cy_r - x_sh;
          cz_r <= cz_r + atan_z;
        end
        step_r <= step_r + 1'b1;
      end
      ocam_pkg::S_COR_END: begin
        if (pass_r) begin
          ca_r <= x_fin[ocam_pkg::MUL_W-1:0];
          sa_r <= y_fin[ocam_pkg::MUL_W-1:0];
        end else begin
          ce_r <= x_fin[ocam_pkg::MUL_W-1:0];
          se_r <= y_fin[ocam_pkg::MUL_W-1:0];
        end
      end
      ocam_pkg::S_MUL_Y: begin
        t_r <= t_sum[47:16];
      end
      ocam_pkg::S_MUL_X: begin
        py_r <= rnd_sat(prod_r, 30);
      end
      ocam_pkg::S_MUL_Z: begin
        px_r <= rnd_sat(prod_r, 44);
      end
      default: ;
    endcase
    if (state_r == ocam_pkg::S_OUT && out_free) begin
      pos_x_r         <= px_r;
      pos_y_r         <= py_r;
      pos_z_r         <= rnd_sat(prod_r, 44);
      cur_radius_r    <= radius_r;
      cur_azimuth_r   <= azimuth_r;
      cur_elevation_r <= elevation_r;
    end
  end

  // control: pass select and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pass_r <= 1'b0;
      end else if (state_r == ocam_pkg::S_COR_END) begin
        pass_r <= 1'b1;
      end
      if (state_r == ocam_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pos_x         = pos_x_r;
  assign out_ch.pos_y         = pos_y_r;
  assign out_ch.pos_z         = pos_z_r;
  assign out_ch.cur_radius    = cur_radius_r;
  assign out_ch.cur_azimuth   = cur_azimuth_r;
  assign out_ch.cur_elevation = cur_elevation_r;

  `OCAM_ASSERT_NXT(a_rotate_converts,
                   in_acc && (in_ch.kind == ocam_pkg::KIND_ROTATE),
                   state_r == ocam_pkg::S_DEG_AZ,
                   "rotate request did not start degree conversion")
  `OCAM_ASSERT_NOW(a_result_from_seq,
                   $rose(out_valid_r),
                   $past(state_r) == ocam_pkg::S_OUT,
                   "result appeared outside output step")
  `OCAM_ASSERT_NXT(a_elev_in_bounds,
                   (state_r == ocam_pkg::S_DEG_FIN) && (elev_min_r <= elev_max_r),
                   (elevation_r >= $past(elev_min_r)) && (elevation_r <= $past(elev_max_r)),
                   "rotated elevation outside clamp")
  `OCAM_ASSERT_NOW(a_trig_bounded,
                   state_r == ocam_pkg::S_MUL_T,
                   (ce_r <= ocam_pkg::TRIG_LIM) && (ce_r >= -ocam_pkg::TRIG_LIM) &&
                   (sa_r <= ocam_pkg::TRIG_LIM) && (sa_r >= -ocam_pkg::TRIG_LIM),
                   "cordic result beyond unit")

endmodule

/* bench/tb_orbit_camera_spherical_to_cartesian.sv */
// testbench of the orbit camera block: random and directed requests checked against a local camera model
module tb_orbit_camera_spherical_to_cartesian;
  import ocam_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;

  // code the block leaves unused: state kept, result still produced
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam longint COS_START = 652032874;
  localparam longint UNIT_Q30  = longint'(1) << 30;
  localparam longint POS_LIM   = 65535;

  // arctan(2^-i) in angle units, 65536 per turn
  localparam int ATAN_BAU [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                   41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [DEG_W-1:0] d_az;
    logic signed [DEG_W-1:0] d_el;
    logic signed [DRAD_W-1:0] d_rad;
    logic [RAD_W-1:0]        l_rad;
    logic [ANG_W-1:0]        l_az;
    logic signed [ANG_W-1:0] l_el;
  } cam_request_t;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [RAD_W-1:0]        cur_radius;
    logic [ANG_W-1:0]        cur_azimuth;
    logic signed [ANG_W-1:0] cur_elevation;
  } cam_view_t;

  logic clk = 1'b0;
  logic rst_n;

  ocam_in_if  in_ch ();
  ocam_out_if out_ch ();
  ocam_cfg_if cfg_ch ();

  orbit_camera_spherical_to_cartesian u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // camera model state and clamp registers
  logic [RAD_W-1:0]        cam_radius;
  logic [ANG_W-1:0]        cam_azimuth;
  logic signed [ANG_W-1:0] cam_elevation;
  logic signed [ANG_W-1:0] elev_lo;
  logic signed [ANG_W-1:0] elev_hi;
  logic [RAD_W-1:0]        rad_lo;
  logic [RAD_W-1:0]        rad_hi;

  cam_view_t pending_views[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        hold_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint deg_to_bau(input logic signed [DEG_W-1:0] d);
    longint v;
    longint q;
    v = d;
    q = ((v < 0 ? -v : v) * 32 + 22) / 45;
    return v < 0 ? -q : q;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input longint v);
    return POS_W'(clip(v, -POS_LIM, POS_LIM));
  endfunction

  // rotation-mode cordic, Q1.30 cos and sin
  function automatic void cordic_trig(input logic [ANG_W-1:0] ang, output longint c,
                                      output longint s);
    logic [ANG_W-1:0] a;
    logic             flip;
    longint           x, y, z, nx;
    a = ang;
    flip = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
    if (flip) a = a + 16'h8000;
    z = longint'($signed(a));
    x = COS_START;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_BAU[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_BAU[i];
      end
      x = nx;
    end
    x = clip(x, -UNIT_Q30, UNIT_Q30);
    y = clip(y, -UNIT_Q30, UNIT_Q30);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic cam_view_t advance_camera(input cam_request_t req);
    cam_view_t v;
    longint    e_lo, e_hi, ec, ce, se, ca, sa, r, t;
    e_lo = elev_lo;
    e_hi = elev_hi;
    case (req.kind)
      KIND_ROTATE: begin
        cam_azimuth = cam_azimuth + 16'(deg_to_bau(req.d_az));
        cam_elevation = 16'(clip(longint'(cam_elevation) + deg_to_bau(req.d_el), e_lo, e_hi));
      end
      KIND_ZOOM: begin
        cam_radius = 16'(clip(longint'(cam_radius) + longint'(req.d_rad),
                              longint'(rad_lo), longint'(rad_hi)));
      end
      KIND_LOAD: begin
        cam_radius = req.l_rad;
        cam_azimuth = req.l_az;
        cam_elevation = req.l_el;
      end
      default: ;
    endcase
    // stored elevation stays raw, only the trig sees it clamped
    ec = clip(longint'(cam_elevation), e_lo, e_hi);
    cordic_trig(16'(ec), ce, se);
    cordic_trig(cam_azimuth, ca, sa);
    r = longint'(cam_radius);
    t = (r * ce + (longint'(1) << 15)) >>> 16;
    v.pos_x = sat_pos((t * sa + (longint'(1) << 43)) >>> 44);
    v.pos_y = sat_pos((r * se + (longint'(1) << 29)) >>> 30);
    v.pos_z = sat_pos((t * ca + (longint'(1) << 43)) >>> 44);
    v.cur_radius = cam_radius;
    v.cur_azimuth = cam_azimuth;
    v.cur_elevation = cam_elevation;
    return v;
  endfunction

  function automatic logic signed [DEG_W-1:0] pick_degrees();
    case ($urandom_range(7))
      0:       return 17'sd46080;
      1:       return -17'sd46080;
      2:       return 17'(int'($urandom_range(512)) - 256);
      default: return 17'(int'($urandom_range(92160)) - 46080);
    endcase
  endfunction

  function automatic logic signed [DRAD_W-1:0] pick_radius_step();
    case ($urandom_range(7))
      0:       return 17'sd65535;
      1:       return -17'sd65535;
      2, 3:    return 17'(int'($urandom_range(4000)) - 2000);
      default: return 17'(int'($urandom_range(131070)) - 65535);
    endcase
  endfunction

  function automatic cam_request_t random_fields(input logic [KIND_W-1:0] kind);
    cam_request_t r;
    r.kind = kind;
    r.d_az = pick_degrees();
    r.d_el = pick_degrees();
    r.d_rad = pick_radius_step();
    r.l_rad = $urandom_range(1) ? 16'($urandom_range(6000)) : 16'($urandom_range(65535));
    r.l_az = 16'($urandom_range(65535));
    r.l_el = 16'($urandom_range(65535));
    return r;
  endfunction

  function automatic cam_request_t random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return random_fields(KIND_ROTATE);
    if (pick < 70) return random_fields(KIND_ZOOM);
    if (pick < 93) return random_fields(KIND_LOAD);
    return random_fields(KIND_NONE);
  endfunction

  function automatic cam_request_t rotate_req(input int daz, input int del);
    cam_request_t r;
    r = random_fields(KIND_ROTATE);
    r.d_az = 17'(daz);
    r.d_el = 17'(del);
    return r;
  endfunction

  function automatic cam_request_t zoom_req(input int drad);
    cam_request_t r;
    r = random_fields(KIND_ZOOM);
    r.d_rad = 17'(drad);
    return r;
  endfunction

  function automatic cam_request_t load_req(input int rad, input int az, input int el);
    cam_request_t r;
    r = random_fields(KIND_LOAD);
    r.l_rad = 16'(rad);
    r.l_az = 16'(az);
    r.l_el = 16'(el);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input cam_request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.kind = req.kind;
    in_ch.delta_azimuth_deg = req.d_az;
    in_ch.delta_elevation_deg = req.d_el;
    in_ch.delta_radius = req.d_rad;
    in_ch.load_radius = req.l_rad;
    in_ch.load_azimuth = req.l_az;
    in_ch.load_elevation = req.l_el;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_views.push_back(advance_camera(req));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_ch.idx = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ELEV_MIN: elev_lo = value;
      CFG_ELEV_MAX: elev_hi = value;
      CFG_RAD_MIN:  rad_lo = value;
      CFG_RAD_MAX:  rad_hi = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_bounds(input int e_min, input int e_max, input int r_min, input int r_max);
    write_register(CFG_ELEV_MIN, 16'(e_min));
    write_register(CFG_ELEV_MAX, 16'(e_max));
    write_register(CFG_RAD_MIN, 16'(r_min));
    write_register(CFG_RAD_MAX, 16'(r_max));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_directed();
    send_request(random_fields(KIND_NONE));
    send_request(zoom_req(0));
    send_request(zoom_req(65535));
    send_request(zoom_req(-65535));
    send_request(rotate_req(46080, 46080));
    send_request(rotate_req(-46080, -46080));
    send_request(rotate_req(1, -1));
    send_request(rotate_req(0, 0));
    send_request(load_req(65535, 0, 0));
    send_request(load_req(65535, 16384, 32767));
    send_request(load_req(65535, 32768, -32768));
    send_request(load_req(65535, 49152, 0));
    send_request(load_req(65535, 65535, 16384));
    send_request(load_req(0, 12345, -100));
    send_request(random_fields(KIND_NONE));
    send_request(load_req(32768, 8192, 4096));
    send_request(rotate_req(1, 0));
    send_request(rotate_req(-1, 1));
    send_request(rotate_req(115, -115));
    send_request(zoom_req(1));
    send_request(zoom_req(-1));
    send_request(load_req(100, 0, -8193));
  endtask

  task automatic test_wide_bounds();
    set_bounds(-32768, 32767, 0, 65535);
    send_random(150);
  endtask

  // lower bound above upper bound: lower check wins
  task automatic test_crossed_bounds();
    set_bounds(4000, -4000, 3000, 100);
    send_random(150);
  endtask

  task automatic test_random_bounds();
    int a, b, c, d;
    repeat (4) begin
      a = $urandom_range(65535);
      b = $urandom_range(65535);
      c = $urandom_range(65535);
      d = $urandom_range(65535);
      if ($urandom_range(1) && $signed(16'(a)) > $signed(16'(b))) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
      if ($urandom_range(1) && c > d) begin
        c = c ^ d;
        d = c ^ d;
        c = c ^ d;
      end
      set_bounds(a, b, c, d);
      send_random(150);
    end
  endtask

  // receiver stalls long enough to back up the input side
  task automatic test_backpressure();
    repeat (2) begin
      hold_cycles = HOLD_CYCLES;
      send_random(12);
      wait_idle();
      send_random(20);
    end
    wait_idle();
  endtask

  task automatic test_default_bounds();
    set_bounds(ELEV_MIN_RST, ELEV_MAX_RST, RAD_MIN_RST, RAD_MAX_RST);
    send_random(400);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    cam_view_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_views.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        check_field("pos_x", 32'(want.pos_x), 32'(out_ch.pos_x));
        check_field("pos_y", 32'(want.pos_y), 32'(out_ch.pos_y));
        check_field("pos_z", 32'(want.pos_z), 32'(out_ch.pos_z));
        check_field("cur_radius", 32'(want.cur_radius), 32'(out_ch.cur_radius));
        check_field("cur_azimuth", 32'(want.cur_azimuth), 32'(out_ch.cur_azimuth));
        check_field("cur_elevation", 32'(want.cur_elevation), 32'(out_ch.cur_elevation));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drive_result_ready
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ROTATE;
    in_ch.delta_azimuth_deg = '0;
    in_ch.delta_elevation_deg = '0;
    in_ch.delta_radius = '0;
    in_ch.load_radius = '0;
    in_ch.load_azimuth = '0;
    in_ch.load_elevation = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = CFG_ELEV_MIN;
    cfg_ch.data = '0;
    cam_radius = '0;
    cam_azimuth = '0;
    cam_elevation = '0;
    elev_lo = ELEV_MIN_RST;
    elev_hi = ELEV_MAX_RST;
    rad_lo = RAD_MIN_RST;
    rad_hi = RAD_MAX_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 19;
    recv_idle_pct = 82;
    test_directed();
    test_wide_bounds();
    test_crossed_bounds();
    send_idle_pct = 82;
    recv_idle_pct = 19;
    test_random_bounds();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_default_bounds();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
